@@ rtl/rfgi_pkg.sv @@
// shared types and constants of the rational function ground-to-image block
// no dependencies; used by every module in rtl/
package rfgi_pkg;

  localparam int DATA_W      = 48;
  localparam int ADDR_W      = 7;
  localparam int TADDR_W     = 5;
  localparam int ACC_W       = 53;
  localparam int STORE_DEPTH = 90;
  localparam int TERMS       = 20;

  localparam logic [DATA_W-1:0] SAT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 48'h8000_0000_0000;

  // store layout
  localparam logic [ADDR_W-1:0] ADDR_GND_OFS  = 7'd80;
  localparam logic [ADDR_W-1:0] ADDR_LINE_OFS = 7'd86;
  localparam logic [ADDR_W-1:0] ADDR_LINE_SCL = 7'd87;
  localparam logic [ADDR_W-1:0] ADDR_TERMS    = 7'd20;
  localparam logic [ADDR_W-1:0] ADDR_DEPTH    = 7'd90;

  // term indices
  localparam logic [TADDR_W-1:0] T_ONE   = 5'd0;
  localparam logic [TADDR_W-1:0] T_X     = 5'd3;
  localparam logic [TADDR_W-1:0] T_FIRST = 5'd4;
  localparam logic [TADDR_W-1:0] T_LAST  = 5'd19;

  typedef enum logic [4:0] {
    S_IDLE, S_NOFF, S_NSCL, S_NDIV, S_NWAIT,
    S_TRD, S_TMUL, S_TWAIT,
    S_DRD, S_DMUL, S_DWAIT, S_DSAVE,
    S_RDIV, S_RWAIT,
    S_LRD, S_LMUL, S_LWAIT, S_LADD,
    S_OUT
  } rfgi_state_e;

  typedef enum logic [1:0] {TW_ONE, TW_DIVQ, TW_MULR} rfgi_twsel_e;
  typedef enum logic {MA_TERM, MA_RATIO} rfgi_masel_e;
  typedef enum logic {MB_TERM, MB_COEF} rfgi_mbsel_e;
  typedef enum logic {DN_DIFF, DN_DOT} rfgi_dnsel_e;
  typedef enum logic {DD_COEF, DD_DOT} rfgi_ddsel_e;

  typedef struct packed {
    logic                take;
    logic [ADDR_W-1:0]   st_addr;
    logic [TADDR_W-1:0]  ta_addr;
    logic [TADDR_W-1:0]  tb_addr;
    logic                t_we;
    logic [TADDR_W-1:0]  t_waddr;
    rfgi_twsel_e         tw_sel;
    logic                diff_en;
    logic [1:0]          coord_sel;
    logic                mul_start;
    rfgi_masel_e         ma_sel;
    rfgi_mbsel_e         mb_sel;
    logic                div_start;
    rfgi_dnsel_e         dn_sel;
    rfgi_ddsel_e         dd_sel;
    logic                acc_clr;
    logic                acc_add;
    logic                dot_we;
    logic                ratio_we;
    logic                res_we;
    logic [1:0]          k;
    logic                out_load;
  } rfgi_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } rfgi_sts_t;

  // first factor of each product term
  function automatic logic [TADDR_W-1:0] term_src_a(input logic [TADDR_W-1:0] idx);
    logic [TADDR_W-1:0] r;
    case (idx)
      5'd4, 5'd5, 5'd7:                     r = 5'd1;
      5'd6, 5'd8:                           r = 5'd2;
      5'd9:                                 r = 5'd3;
      5'd10:                                r = 5'd4;
      5'd11, 5'd12, 5'd17:                  r = 5'd7;
      5'd13, 5'd14, 5'd18:                  r = 5'd8;
      5'd15, 5'd16, 5'd19:                  r = 5'd9;
      default:                              r = 5'd0;
    endcase
    return r;
  endfunction

  // second factor of each product term
  function automatic logic [TADDR_W-1:0] term_src_b(input logic [TADDR_W-1:0] idx);
    logic [TADDR_W-1:0] r;
    case (idx)
      5'd7, 5'd13, 5'd15, 5'd17:            r = 5'd1;
      5'd4, 5'd8, 5'd11, 5'd16, 5'd18:      r = 5'd2;
      5'd5, 5'd6, 5'd9, 5'd10, 5'd12,
      5'd14, 5'd19:                         r = 5'd3;
      default:                              r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/rational_function_ground_to_image.sv @@
// a store word is written into the coefficient store when it is taken; a ground point
// makes 98 passes through the multiplier and five bit-serial divides of 49 + FRAC_BITS
// steps each before its result is registered, which waits until the output is free
// a zero divisor skips the bit-serial steps and gives a saturated quotient; the next word is
// taken once the result is registered, while that result waits at the output
// reset: rst_ni asynchronous, active low; the coefficient store is not cleared
module rational_function_ground_to_image #(
  parameter int FRAC_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic        [rfgi_pkg::ADDR_W-1:0]  coeff_index_i,
  input  logic signed [rfgi_pkg::DATA_W-1:0]  coeff_value_i,
  input  logic signed [31:0]                  latitude_i,
  input  logic signed [31:0]                  longitude_i,
  input  logic signed [31:0]                  height_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rfgi_pkg::DATA_W-1:0]  image_line_o,
  output logic signed [rfgi_pkg::DATA_W-1:0]  image_sample_o,
  output logic                                divide_fault_o
);

  rfgi_pkg::rfgi_cmd_t cmd;
  rfgi_pkg::rfgi_sts_t sts;

  // sequencer
  rfgi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // arithmetic and storage
  rfgi_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .coeff_index_i  (coeff_index_i),
    .coeff_value_i  (coeff_value_i),
    .latitude_i     (latitude_i),
    .longitude_i    (longitude_i),
    .height_i       (height_i),
    .image_line_o   (image_line_o),
    .image_sample_o (image_sample_o),
    .divide_fault_o (divide_fault_o)
  );

endmodule

@@ rtl/rfgi_mul.sv @@
// sequential signed fixed point multiplier, four 24x24 partial products
// depends on rfgi_pkg
module rfgi_mul #(
  parameter int FRAC_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [rfgi_pkg::DATA_W-1:0]  a_i,
  input  logic signed [rfgi_pkg::DATA_W-1:0]  b_i,
  output logic                                done_o,
  output logic        [rfgi_pkg::DATA_W-1:0]  res_o
);

  localparam int PW = 2 * rfgi_pkg::DATA_W;
  localparam int HW = rfgi_pkg::DATA_W / 2;

  logic [rfgi_pkg::DATA_W-1:0] ma_q, mb_q;
  logic                        neg_q;
  logic [PW-1:0]               acc_q;
  logic [1:0]                  step_q;
  logic                        busy_q, fin_q, done_q;
  logic [rfgi_pkg::DATA_W-1:0] res_q;
  logic [HW-1:0]               half_a, half_b;
  logic [2*HW-1:0]             pp;
  logic [PW-1:0]               pp_sh, shr;
  logic                        big;
  logic [rfgi_pkg::DATA_W-1:0] ma_d, mb_d, res_d;

  // operand magnitudes
  assign ma_d = a_i[rfgi_pkg::DATA_W-1] ? rfgi_pkg::DATA_W'(-a_i) : a_i;
  assign mb_d = b_i[rfgi_pkg::DATA_W-1] ? rfgi_pkg::DATA_W'(-b_i) : b_i;

  // partial product for this step
  always_comb begin
    half_a = step_q[0] ? ma_q[2*HW-1:HW] : ma_q[HW-1:0];
    half_b = step_q[1] ? mb_q[2*HW-1:HW] : mb_q[HW-1:0];
    pp     = half_a * half_b;
    case (step_q)
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << (2 * HW);
      default: pp_sh = PW'(pp) << HW;
    endcase
  end

  // truncate, then saturate by sign
  always_comb begin
    shr = acc_q >> FRAC_BITS;
    big = |shr[PW-1:rfgi_pkg::DATA_W-1];
    if (big) begin
      res_d = neg_q ? rfgi_pkg::SAT_MIN : rfgi_pkg::SAT_MAX;
    end else begin
      res_d = neg_q ? rfgi_pkg::DATA_W'(-shr[rfgi_pkg::DATA_W-1:0]) : shr[rfgi_pkg::DATA_W-1:0];
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // operand and product registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      neg_q <= a_i[rfgi_pkg::DATA_W-1] ^ b_i[rfgi_pkg::DATA_W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/rfgi_div.sv @@
// restoring bit-serial divider giving (a * 2^FRAC_BITS) / b, saturated
// depends on rfgi_pkg
module rfgi_div #(
  parameter int FRAC_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [rfgi_pkg::DATA_W:0]    num_i,
  input  logic signed [rfgi_pkg::DATA_W-1:0]  den_i,
  output logic                                done_o,
  output logic        [rfgi_pkg::DATA_W-1:0]  res_o
);

  localparam int NW    = rfgi_pkg::DATA_W + 1;
  localparam int NUM_W = NW + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]            num_q;
  logic [rfgi_pkg::DATA_W-1:0] den_q, quo_q, res_q, res_d;
  logic [NW-1:0]               rem_q, rem_n, num_mag;
  logic                        ovf_q, neg_q, busy_q, fin_q, done_q, ge;
  logic [CNT_W-1:0]            cnt_q;

  assign num_mag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);

  // one quotient bit per cycle
  always_comb begin
    rem_n = {rem_q[NW-2:0], num_q[NUM_W-1]};
    ge    = rem_n >= {1'b0, den_q};
  end

  // final saturation
  always_comb begin
    if (ovf_q || quo_q[rfgi_pkg::DATA_W-1]) begin
      res_d = neg_q ? rfgi_pkg::SAT_MIN : rfgi_pkg::SAT_MAX;
    end else begin
      res_d = neg_q ? rfgi_pkg::DATA_W'(-quo_q) : quo_q;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(NUM_W - 1);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {num_mag, {FRAC_BITS{1'b0}}};
      den_q <= den_i[rfgi_pkg::DATA_W-1] ? rfgi_pkg::DATA_W'(-den_i) : den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= num_i[NW-1] ^ den_i[rfgi_pkg::DATA_W-1];
      if (den_i == '0) begin
        res_q <= num_i[NW-1] ? rfgi_pkg::SAT_MIN : rfgi_pkg::SAT_MAX;
      end
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= ge ? rem_n - {1'b0, den_q} : rem_n;
      quo_q <= {quo_q[rfgi_pkg::DATA_W-2:0], ge};
      ovf_q <= ovf_q | quo_q[rfgi_pkg::DATA_W-1];
    end else if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/rfgi_dpath.sv @@
// datapath: coefficient store, term memory, accumulator, multiplier, divider
// depends on rfgi_pkg, rfgi_mul, rfgi_div
module rfgi_dpath #(
  parameter int FRAC_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rfgi_pkg::rfgi_cmd_t                 cmd_i,
  output rfgi_pkg::rfgi_sts_t                 sts_o,
  input  logic                                kind_i,
  input  logic        [rfgi_pkg::ADDR_W-1:0]  coeff_index_i,
  input  logic signed [rfgi_pkg::DATA_W-1:0]  coeff_value_i,
  input  logic signed [31:0]                  latitude_i,
  input  logic signed [31:0]                  longitude_i,
  input  logic signed [31:0]                  height_i,
  output logic signed [rfgi_pkg::DATA_W-1:0]  image_line_o,
  output logic signed [rfgi_pkg::DATA_W-1:0]  image_sample_o,
  output logic                                divide_fault_o
);

  localparam int DW = rfgi_pkg::DATA_W;
  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;
  localparam logic signed [63:0] W_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] W_MIN = -64'sh0000_8000_0000_0000;

  logic [DW-1:0] store_mem [rfgi_pkg::STORE_DEPTH];
  logic [DW-1:0] t_mem [rfgi_pkg::TERMS];
  logic [DW-1:0] coef_q, ta_q, tb_q;
  logic signed [31:0] lat_q, lon_q, hgt_q, coord;
  logic signed [63:0] wide;
  logic [DW-1:0] coord_v;
  logic [DW:0]   diff_q, diff_d, div_num;
  logic [rfgi_pkg::ACC_W-1:0] acc_q;
  logic [DW-1:0] dln_q, dld_q, dsn_q, dsd_q, rl_q, rs_q, rline_q, rsamp_q;
  logic [DW-1:0] acc_sat, mul_a, mul_b, div_den, mul_res, div_res, t_wdata, res_sat;
  logic [DW:0]   res_sum;
  logic          flt_q, mul_done, div_done;
  logic [DW-1:0] line_q, samp_q;
  logic          fault_q;

  // coefficient store: write on load words, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !kind_i && (coeff_index_i < rfgi_pkg::ADDR_DEPTH)) begin
      store_mem[coeff_index_i] <= coeff_value_i;
    end
    coef_q <= store_mem[cmd_i.st_addr];
  end

  // term memory: one write, two registered reads
  always_comb begin
    case (cmd_i.tw_sel)
      rfgi_pkg::TW_ONE:  t_wdata = ONE;
      rfgi_pkg::TW_DIVQ: t_wdata = div_res;
      default:           t_wdata = mul_res;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.t_we) begin
      t_mem[cmd_i.t_waddr] <= t_wdata;
    end
    ta_q <= t_mem[cmd_i.ta_addr];
    tb_q <= t_mem[cmd_i.tb_addr];
  end

  // widen ground coordinate and subtract offset
  always_comb begin
    case (cmd_i.coord_sel)
      2'd0:    coord = lat_q;
      2'd1:    coord = lon_q;
      default: coord = hgt_q;
    endcase
    wide = 64'(coord) <<< (FRAC_BITS - 16);
    if (wide > W_MAX) begin
      coord_v = rfgi_pkg::SAT_MAX;
    end else if (wide < W_MIN) begin
      coord_v = rfgi_pkg::SAT_MIN;
    end else begin
      coord_v = wide[DW-1:0];
    end
    diff_d = {coord_v[DW-1], coord_v} - {coef_q[DW-1], coef_q};
  end

  // operand selection
  always_comb begin
    mul_a   = (cmd_i.ma_sel == rfgi_pkg::MA_RATIO) ? (cmd_i.k[0] ? rs_q : rl_q) : ta_q;
    mul_b   = (cmd_i.mb_sel == rfgi_pkg::MB_COEF) ? coef_q : tb_q;
    if (cmd_i.dn_sel == rfgi_pkg::DN_DOT) begin
      div_num = cmd_i.k[0] ? {dsn_q[DW-1], dsn_q} : {dln_q[DW-1], dln_q};
    end else begin
      div_num = diff_q;
    end
    if (cmd_i.dd_sel == rfgi_pkg::DD_DOT) begin
      div_den = cmd_i.k[0] ? dsd_q : dld_q;
    end else begin
      div_den = coef_q;
    end
  end

  // saturate the dot sum and the denormalised result
  always_comb begin
    if (&acc_q[rfgi_pkg::ACC_W-1:DW-1] || ~|acc_q[rfgi_pkg::ACC_W-1:DW-1]) begin
      acc_sat = acc_q[DW-1:0];
    end else begin
      acc_sat = acc_q[rfgi_pkg::ACC_W-1] ? rfgi_pkg::SAT_MIN : rfgi_pkg::SAT_MAX;
    end
    res_sum = {mul_res[DW-1], mul_res} + {coef_q[DW-1], coef_q};
    if (res_sum[DW] != res_sum[DW-1]) begin
      res_sat = res_sum[DW] ? rfgi_pkg::SAT_MIN : rfgi_pkg::SAT_MAX;
    end else begin
      res_sat = res_sum[DW-1:0];
    end
  end

  // fault flag is sticky over one ground point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flt_q <= 1'b0;
    end else if (cmd_i.take) begin
      flt_q <= 1'b0;
    end else if (cmd_i.div_start && (div_den == '0)) begin
      flt_q <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && kind_i) begin
      lat_q <= latitude_i;
      lon_q <= longitude_i;
      hgt_q <= height_i;
    end
    if (cmd_i.diff_en) begin
      diff_q <= diff_d;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + {{(rfgi_pkg::ACC_W-DW){mul_res[DW-1]}}, mul_res};
    end
    if (cmd_i.dot_we) begin
      case (cmd_i.k)
        2'd0:    dln_q <= acc_sat;
        2'd1:    dld_q <= acc_sat;
        2'd2:    dsn_q <= acc_sat;
        default: dsd_q <= acc_sat;
      endcase
    end
    if (cmd_i.ratio_we) begin
      if (cmd_i.k[0]) begin
        rs_q <= div_res;
      end else begin
        rl_q <= div_res;
      end
    end
    if (cmd_i.res_we) begin
      if (cmd_i.k[0]) begin
        rsamp_q <= res_sat;
      end else begin
        rline_q <= res_sat;
      end
    end
    if (cmd_i.out_load) begin
      line_q  <= rline_q;
      samp_q  <= rsamp_q;
      fault_q <= flt_q;
    end
  end

  // shared arithmetic units
  rfgi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  rfgi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign image_line_o   = line_q;
  assign image_sample_o = samp_q;
  assign divide_fault_o = fault_q;

endmodule

@@ rtl/rfgi_ctrl.sv @@
// controller: sequences normalise, term, dot, ratio and denormalise steps
// depends on rfgi_pkg
module rfgi_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 kind_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rfgi_pkg::rfgi_cmd_t  cmd_o,
  input  rfgi_pkg::rfgi_sts_t  sts_i
);

  rfgi_pkg::rfgi_state_e state_q, state_d;
  logic [rfgi_pkg::TADDR_W-1:0] cnt_q, cnt_d;
  logic [1:0] k_q, k_d;
  logic out_valid_q, take, out_free;

  assign take     = in_valid_i && (state_q == rfgi_pkg::S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // next state and counters
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    case (state_q)
      rfgi_pkg::S_IDLE: begin
        if (take && kind_i) begin
          state_d = rfgi_pkg::S_NOFF;
          cnt_d   = '0;
        end
      end
      rfgi_pkg::S_NOFF: state_d = rfgi_pkg::S_NSCL;
      rfgi_pkg::S_NSCL: state_d = rfgi_pkg::S_NDIV;
      rfgi_pkg::S_NDIV: state_d = rfgi_pkg::S_NWAIT;
      rfgi_pkg::S_NWAIT: begin
        if (sts_i.div_done) begin
          if (cnt_q == 5'd2) begin
            cnt_d   = rfgi_pkg::T_FIRST;
            state_d = rfgi_pkg::S_TRD;
          end else begin
            cnt_d   = cnt_q + 5'd1;
            state_d = rfgi_pkg::S_NOFF;
          end
        end
      end
      rfgi_pkg::S_TRD:  state_d = rfgi_pkg::S_TMUL;
      rfgi_pkg::S_TMUL: state_d = rfgi_pkg::S_TWAIT;
      rfgi_pkg::S_TWAIT: begin
        if (sts_i.mul_done) begin
          if (cnt_q == rfgi_pkg::T_LAST) begin
            cnt_d   = '0;
            k_d     = 2'd0;
            state_d = rfgi_pkg::S_DRD;
          end else begin
            cnt_d   = cnt_q + 5'd1;
            state_d = rfgi_pkg::S_TRD;
          end
        end
      end
      rfgi_pkg::S_DRD:  state_d = rfgi_pkg::S_DMUL;
      rfgi_pkg::S_DMUL: state_d = rfgi_pkg::S_DWAIT;
      rfgi_pkg::S_DWAIT: begin
        if (sts_i.mul_done) begin
          if (cnt_q == rfgi_pkg::T_LAST) begin
            state_d = rfgi_pkg::S_DSAVE;
          end else begin
            cnt_d   = cnt_q + 5'd1;
            state_d = rfgi_pkg::S_DRD;
          end
        end
      end
      rfgi_pkg::S_DSAVE: begin
        cnt_d = '0;
        if (k_q == 2'd3) begin
          k_d     = 2'd0;
          state_d = rfgi_pkg::S_RDIV;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = rfgi_pkg::S_DRD;
        end
      end
      rfgi_pkg::S_RDIV: state_d = rfgi_pkg::S_RWAIT;
      rfgi_pkg::S_RWAIT: begin
        if (sts_i.div_done) begin
          if (k_q == 2'd1) begin
            k_d     = 2'd0;
            state_d = rfgi_pkg::S_LRD;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = rfgi_pkg::S_RDIV;
          end
        end
      end
      rfgi_pkg::S_LRD:  state_d = rfgi_pkg::S_LMUL;
      rfgi_pkg::S_LMUL: state_d = rfgi_pkg::S_LWAIT;
      rfgi_pkg::S_LWAIT: begin
        if (sts_i.mul_done) begin
          state_d = rfgi_pkg::S_LADD;
        end
      end
      rfgi_pkg::S_LADD: begin
        if (k_q == 2'd1) begin
          state_d = rfgi_pkg::S_OUT;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = rfgi_pkg::S_LRD;
        end
      end
      rfgi_pkg::S_OUT: begin
        if (out_free) begin
          state_d = rfgi_pkg::S_IDLE;
        end
      end
      default: state_d = rfgi_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.tw_sel    = rfgi_pkg::TW_MULR;
    cmd_o.ma_sel    = rfgi_pkg::MA_TERM;
    cmd_o.mb_sel    = rfgi_pkg::MB_TERM;
    cmd_o.dn_sel    = rfgi_pkg::DN_DIFF;
    cmd_o.dd_sel    = rfgi_pkg::DD_COEF;
    cmd_o.take      = take;
    cmd_o.k         = k_q;
    cmd_o.coord_sel = cnt_q[1:0];
    case (state_q)
      rfgi_pkg::S_NOFF: begin
        cmd_o.st_addr = rfgi_pkg::ADDR_GND_OFS + 7'({cnt_q, 1'b0});
        cmd_o.t_we    = 1'b1;
        cmd_o.t_waddr = rfgi_pkg::T_ONE;
        cmd_o.tw_sel  = rfgi_pkg::TW_ONE;
      end
      rfgi_pkg::S_NSCL: begin
        cmd_o.st_addr = rfgi_pkg::ADDR_GND_OFS + 7'({cnt_q, 1'b1});
        cmd_o.diff_en = 1'b1;
      end
      rfgi_pkg::S_NDIV: cmd_o.div_start = 1'b1;
      rfgi_pkg::S_NWAIT: begin
        cmd_o.t_we    = sts_i.div_done;
        cmd_o.t_waddr = rfgi_pkg::T_X - cnt_q;
        cmd_o.tw_sel  = rfgi_pkg::TW_DIVQ;
      end
      rfgi_pkg::S_TRD: begin
        cmd_o.ta_addr = rfgi_pkg::term_src_a(cnt_q);
        cmd_o.tb_addr = rfgi_pkg::term_src_b(cnt_q);
      end
      rfgi_pkg::S_TMUL: cmd_o.mul_start = 1'b1;
      rfgi_pkg::S_TWAIT: begin
        cmd_o.t_we    = sts_i.mul_done;
        cmd_o.t_waddr = cnt_q;
      end
      rfgi_pkg::S_DRD: begin
        cmd_o.st_addr = 7'(k_q) * rfgi_pkg::ADDR_TERMS + 7'(cnt_q);
        cmd_o.ta_addr = cnt_q;
        cmd_o.acc_clr = (cnt_q == '0);
      end
      rfgi_pkg::S_DMUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mb_sel    = rfgi_pkg::MB_COEF;
      end
      rfgi_pkg::S_DWAIT: cmd_o.acc_add = sts_i.mul_done;
      rfgi_pkg::S_DSAVE: cmd_o.dot_we = 1'b1;
      rfgi_pkg::S_RDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.dn_sel    = rfgi_pkg::DN_DOT;
        cmd_o.dd_sel    = rfgi_pkg::DD_DOT;
      end
      rfgi_pkg::S_RWAIT: cmd_o.ratio_we = sts_i.div_done;
      rfgi_pkg::S_LRD: cmd_o.st_addr = rfgi_pkg::ADDR_LINE_SCL + 7'({k_q, 1'b0});
      rfgi_pkg::S_LMUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.ma_sel    = rfgi_pkg::MA_RATIO;
        cmd_o.mb_sel    = rfgi_pkg::MB_COEF;
      end
      rfgi_pkg::S_LWAIT: cmd_o.st_addr = rfgi_pkg::ADDR_LINE_OFS + 7'({k_q, 1'b0});
      rfgi_pkg::S_LADD: cmd_o.res_we = 1'b1;
      rfgi_pkg::S_OUT: cmd_o.out_load = out_free;
      default: cmd_o.take = take;
    endcase
  end

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rfgi_pkg::S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == rfgi_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_point_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && kind_i) |=> (state_q == rfgi_pkg::S_NOFF))
    else $error("ground point did not start normalisation");
  a_mul_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> (state_q == rfgi_pkg::S_TWAIT || state_q == rfgi_pkg::S_DWAIT
                        || state_q == rfgi_pkg::S_LWAIT))
    else $error("multiplier finished outside a wait state");
  a_div_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == rfgi_pkg::S_NWAIT || state_q == rfgi_pkg::S_RWAIT))
    else $error("divider finished outside a wait state");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten before it was taken");
`endif

endmodule
